FILE: sv/matrix_inverse_3x3_core_macros.svh
// Assertion macros shared by the RTL files.
`ifndef MATRIX_INVERSE_3X3_CORE_MACROS_SVH
`define MATRIX_INVERSE_3X3_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MI3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MI3_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MI3_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MI3_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/mi3_pkg.sv
package mi3_pkg;

    localparam int ELEM_W   = 32;
    localparam int COF_W    = 64;
    localparam int TERM_W   = 97;
    localparam int DET_W    = 100;
    localparam int MAG_W    = 99;
    localparam int REM_W    = 100;
    localparam int Q_W      = 32;
    localparam int FRAC_SH  = 32;
    localparam int NUM_ELEM = 9;
    localparam int THR_W    = 31;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic REG_THR = 1'b0;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    // adj[k] = m[i0]*m[i1] - m[i2]*m[i3]
    localparam int unsigned COF_IDX [NUM_ELEM][4] = '{
        '{4, 8, 5, 7}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 1, 3}
    };

    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0] mat_t;
    typedef logic [NUM_ELEM-1:0][COF_W-1:0]  adj_t;

    typedef struct packed {
        logic [MAG_W-1:0]    dmag;
        logic [NUM_ELEM-1:0] neg;
        logic                singular;
    } dinfo_t;

    function automatic logic signed [63:0] mul_ss(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        ax = 64'(a);
        bx = 64'(b);
        return ax * bx;
    endfunction

    function automatic logic signed [63:0] mul_su(input logic signed [31:0] a,
                                                  input logic [31:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        ax = 64'(a);
        bx = {32'b0, b};
        return ax * bx;
    endfunction

endpackage

FILE: sv/mi3_cofactor.sv
module mi3_cofactor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mi3_pkg::mat_t in_mat,
    output logic          out_valid,
    input  logic          out_ready,
    output mi3_pkg::mat_t out_mat,
    output mi3_pkg::adj_t out_adj
);

    logic                 va_reg;
    logic                 vb_reg;
    logic                 en_a;
    logic                 en_b;
    mi3_pkg::mat_t        mat_a_reg;
    mi3_pkg::mat_t        mat_b_reg;
    logic signed [63:0]   prod_reg [2*mi3_pkg::NUM_ELEM];
    mi3_pkg::adj_t        adj_b_reg;

    assign en_b     = !vb_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= in_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mat_a_reg <= in_mat;
            for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
            begin
                prod_reg[2*k]   <= mi3_pkg::mul_ss(in_mat[mi3_pkg::COF_IDX[k][0]],
                                                   in_mat[mi3_pkg::COF_IDX[k][1]]);
                prod_reg[2*k+1] <= mi3_pkg::mul_ss(in_mat[mi3_pkg::COF_IDX[k][2]],
                                                   in_mat[mi3_pkg::COF_IDX[k][3]]);
            end
        end
        if (en_b)
        begin
            mat_b_reg <= mat_a_reg;
            for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
            begin
                adj_b_reg[k] <= prod_reg[2*k] - prod_reg[2*k+1];
            end
        end
    end

    assign out_valid = vb_reg;
    assign out_mat   = mat_b_reg;
    assign out_adj   = adj_b_reg;

endmodule

FILE: sv/mi3_det.sv
module mi3_det (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mi3_pkg::THR_W-1:0]   threshold,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mi3_pkg::mat_t               in_mat,
    input  mi3_pkg::adj_t               in_adj,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mi3_pkg::adj_t               out_cmag,
    output mi3_pkg::dinfo_t             out_info
);

    logic vc_reg, vd_reg, ve_reg, vf_reg;
    logic en_c, en_d, en_e, en_f;

    logic signed [63:0]                  plo_c_reg [3];
    logic signed [63:0]                  phi_c_reg [3];
    logic signed [mi3_pkg::TERM_W-1:0]   t_d_reg [3];
    logic signed [mi3_pkg::DET_W-1:0]    det_e_reg;
    mi3_pkg::adj_t                       adj_c_reg;
    mi3_pkg::adj_t                       adj_d_reg;
    mi3_pkg::adj_t                       adj_e_reg;
    mi3_pkg::adj_t                       cmag_f_reg;
    mi3_pkg::dinfo_t                     info_f_reg;

    logic signed [mi3_pkg::DET_W-1:0]    lim;
    logic signed [mi3_pkg::DET_W-1:0]    lim_neg;
    logic signed [mi3_pkg::DET_W-1:0]    det_abs;
    logic                                dneg;

    assign en_f     = !vf_reg || out_ready;
    assign en_e     = !ve_reg || en_f;
    assign en_d     = !vd_reg || en_e;
    assign en_c     = !vc_reg || en_d;
    assign in_ready = en_c;

    assign lim     = {{(mi3_pkg::DET_W-mi3_pkg::THR_W-mi3_pkg::FRAC_SH){1'b0}},
                      threshold, {mi3_pkg::FRAC_SH{1'b0}}};
    assign lim_neg = -lim;
    assign dneg    = det_e_reg[mi3_pkg::DET_W-1];
    assign det_abs = dneg ? -det_e_reg : det_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            if (en_c)
            begin
                vc_reg <= in_valid;
            end
            if (en_d)
            begin
                vd_reg <= vc_reg;
            end
            if (en_e)
            begin
                ve_reg <= vd_reg;
            end
            if (en_f)
            begin
                vf_reg <= ve_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            adj_c_reg <= in_adj;
            for (int i = 0; i < 3; i++)
            begin
                plo_c_reg[i] <= mi3_pkg::mul_su(in_mat[i], in_adj[3*i][31:0]);
                phi_c_reg[i] <= mi3_pkg::mul_ss(in_mat[i], in_adj[3*i][63:32]);
            end
        end
        if (en_d)
        begin
            adj_d_reg <= adj_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                t_d_reg[i] <= {phi_c_reg[i][63], phi_c_reg[i], 32'b0}
                            + {{33{plo_c_reg[i][63]}}, plo_c_reg[i]};
            end
        end
        if (en_e)
        begin
            adj_e_reg <= adj_d_reg;
            det_e_reg <= mi3_pkg::DET_W'(t_d_reg[0]) + mi3_pkg::DET_W'(t_d_reg[1])
                       + mi3_pkg::DET_W'(t_d_reg[2]);
        end
        if (en_f)
        begin
            info_f_reg.singular <= (det_e_reg <= lim) && (det_e_reg >= lim_neg);
            info_f_reg.dmag     <= det_abs[mi3_pkg::MAG_W-1:0];
            for (int k = 0; k < mi3_pkg::NUM_ELEM; k++)
            begin
                cmag_f_reg[k]      <= adj_e_reg[k][63] ? -adj_e_reg[k] : adj_e_reg[k];
                info_f_reg.neg[k]  <= adj_e_reg[k][63] ^ dneg;
            end
        end
    end

    assign out_valid = vf_reg;
    assign out_cmag  = cmag_f_reg;
    assign out_info  = info_f_reg;

endmodule

FILE: sv/mi3_div.sv
`include "matrix_inverse_3x3_core_macros.svh"

module mi3_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mi3_pkg::adj_t    in_cmag,
    input  mi3_pkg::dinfo_t  in_info,
    output logic             out_valid,
    input  logic             out_ready,
    output mi3_pkg::mat_t    out_res,
    output logic             out_singular
);

    localparam int NSTG = mi3_pkg::Q_W + 2;
    localparam int NE   = mi3_pkg::NUM_ELEM;
    localparam int RW   = mi3_pkg::REM_W;
    localparam int QW   = mi3_pkg::Q_W;

    logic                v_reg    [NSTG];
    logic                en       [NSTG+1];
    logic [RW-1:0]       rem_reg  [NSTG][NE];
    logic [QW-1:0]       q_reg    [NSTG][NE];
    logic [NE-1:0]       ovf_reg  [NSTG];
    logic [RW-1:0]       den_reg  [NSTG];
    logic [QW-1:0]       low_reg  [NSTG];
    logic [NE-1:0]       neg_reg  [NSTG];
    logic                sing_reg [NSTG];

    logic                vo_reg;
    mi3_pkg::mat_t       res_reg;
    logic                sing_o_reg;
    logic [RW-1:0]       num [NE];

    assign en[NSTG] = !vo_reg || out_ready;
    assign in_ready = en[0];

    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            num[k] = RW'({in_cmag[k], 33'b0}) + RW'(in_info.dmag);
        end
    end

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stg
            assign en[s] = !v_reg[s] || en[s+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en[s])
                begin
                    if (s == 0)
                    begin
                        v_reg[s] <= in_valid;
                    end
                    else
                    begin
                        v_reg[s] <= v_reg[s-1];
                    end
                end
            end

            if (s == 0)
            begin : g_prep
                always_ff @(posedge clk)
                begin
                    if (en[s])
                    begin
                        den_reg[s]  <= {in_info.dmag, 1'b0};
                        low_reg[s]  <= in_info.dmag[QW-1:0];
                        neg_reg[s]  <= in_info.neg;
                        sing_reg[s] <= in_info.singular;
                        ovf_reg[s]  <= '0;
                        for (int k = 0; k < NE; k++)
                        begin
                            rem_reg[s][k] <= num[k] >> mi3_pkg::FRAC_SH;
                            q_reg[s][k]   <= '0;
                        end
                    end
                end
            end
            else if (s == 1)
            begin : g_ovf
                always_ff @(posedge clk)
                begin
                    if (en[s])
                    begin
                        den_reg[s]  <= den_reg[s-1];
                        low_reg[s]  <= low_reg[s-1];
                        neg_reg[s]  <= neg_reg[s-1];
                        sing_reg[s] <= sing_reg[s-1];
                        for (int k = 0; k < NE; k++)
                        begin
                            ovf_reg[s][k] <= rem_reg[s-1][k] >= den_reg[s-1];
                            rem_reg[s][k] <= rem_reg[s-1][k];
                            q_reg[s][k]   <= q_reg[s-1][k];
                        end
                    end
                end
            end
            else
            begin : g_step
                logic [RW-1:0] r2 [NE];
                logic [NE-1:0] ge;

                always_comb
                begin
                    for (int k = 0; k < NE; k++)
                    begin
                        r2[k] = {rem_reg[s-1][k][RW-2:0], low_reg[s-1][QW-1]};
                        ge[k] = r2[k] >= den_reg[s-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[s])
                    begin
                        den_reg[s]  <= den_reg[s-1];
                        low_reg[s]  <= {low_reg[s-1][QW-2:0], 1'b0};
                        neg_reg[s]  <= neg_reg[s-1];
                        sing_reg[s] <= sing_reg[s-1];
                        ovf_reg[s]  <= ovf_reg[s-1];
                        for (int k = 0; k < NE; k++)
                        begin
                            rem_reg[s][k] <= ge[k] ? r2[k] - den_reg[s-1] : r2[k];
                            q_reg[s][k]   <= {q_reg[s-1][k][QW-2:0], ge[k]};
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en[NSTG])
        begin
            vo_reg <= v_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG])
        begin
            sing_o_reg <= sing_reg[NSTG-1];
            for (int k = 0; k < NE; k++)
            begin
                if (sing_reg[NSTG-1])
                begin
                    res_reg[k] <= '0;
                end
                else if (ovf_reg[NSTG-1][k])
                begin
                    res_reg[k] <= neg_reg[NSTG-1][k] ? mi3_pkg::Q_MIN : mi3_pkg::Q_MAX;
                end
                else if (neg_reg[NSTG-1][k])
                begin
                    res_reg[k] <= (q_reg[NSTG-1][k] > mi3_pkg::Q_MIN) ? mi3_pkg::Q_MIN
                                                                     : -q_reg[NSTG-1][k];
                end
                else
                begin
                    res_reg[k] <= (q_reg[NSTG-1][k] > mi3_pkg::Q_MAX) ? mi3_pkg::Q_MAX
                                                                     : q_reg[NSTG-1][k];
                end
            end
        end
    end

    assign out_valid    = vo_reg;
    assign out_res      = res_reg;
    assign out_singular = sing_o_reg;

    `MI3_ASSERT_IMP(a_rem_below_den, clk, rst_n, v_reg[NSTG-1] && !ovf_reg[NSTG-1][0], rem_reg[NSTG-1][0] < den_reg[NSTG-1])

endmodule

FILE: sv/matrix_inverse_3x3_core.sv
// Channel  | Handshake                 | Beat
// ---------+---------------------------+--------------------------------
// matrix   | mat_valid / mat_ready     | a00..a22, signed Q16.16
// inverse  | inv_valid / inv_ready     | b00..b22 Q16.16 saturated, singular
// config   | APB psel/penable/pwrite   | singular_threshold at 0x0
//
// One matrix beat accepted per cycle unless a stall on the inverse side backs up to mat_ready.
// The divider runs 32 restoring quotient steps, one per stage, nine lanes wide.
// Reset clears all stage valid bits and the threshold.
// A stall on the inverse side holds each full stage; empty stages still fill.
`include "matrix_inverse_3x3_core_macros.svh"

module matrix_inverse_3x3_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mi3_pkg::ADDR_W-1:0]    paddr,
    input  logic [mi3_pkg::DATA_W-1:0]    pwdata,
    output logic [mi3_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          mat_valid,
    output logic                          mat_ready,
    input  logic signed [31:0]            a00,
    input  logic signed [31:0]            a01,
    input  logic signed [31:0]            a02,
    input  logic signed [31:0]            a10,
    input  logic signed [31:0]            a11,
    input  logic signed [31:0]            a12,
    input  logic signed [31:0]            a20,
    input  logic signed [31:0]            a21,
    input  logic signed [31:0]            a22,
    output logic                          inv_valid,
    input  logic                          inv_ready,
    output logic signed [31:0]            b00,
    output logic signed [31:0]            b01,
    output logic signed [31:0]            b02,
    output logic signed [31:0]            b10,
    output logic signed [31:0]            b11,
    output logic signed [31:0]            b12,
    output logic signed [31:0]            b20,
    output logic signed [31:0]            b21,
    output logic signed [31:0]            b22,
    output logic                          singular
);

    logic [mi3_pkg::THR_W-1:0] thr_reg;
    logic                      wr_thr;

    mi3_pkg::mat_t    mat;
    mi3_pkg::mat_t    cof_mat;
    mi3_pkg::adj_t    cof_adj;
    mi3_pkg::adj_t    det_cmag;
    mi3_pkg::dinfo_t  det_info;
    mi3_pkg::mat_t    res;
    logic             cof_valid, cof_ready;
    logic             det_valid, det_ready;

    assign pready = 1'b1;
    assign wr_thr = psel && penable && pwrite && (paddr[2] == mi3_pkg::REG_THR);
    assign prdata = (paddr[2] == mi3_pkg::REG_THR) ? {1'b0, thr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (wr_thr)
        begin
            thr_reg <= pwdata[mi3_pkg::THR_W-1:0];
        end
    end

    assign mat[0] = a00;
    assign mat[1] = a01;
    assign mat[2] = a02;
    assign mat[3] = a10;
    assign mat[4] = a11;
    assign mat[5] = a12;
    assign mat[6] = a20;
    assign mat[7] = a21;
    assign mat[8] = a22;

    mi3_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_mat    (mat),
        .out_valid (cof_valid),
        .out_ready (cof_ready),
        .out_mat   (cof_mat),
        .out_adj   (cof_adj)
    );

    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .in_valid  (cof_valid),
        .in_ready  (cof_ready),
        .in_mat    (cof_mat),
        .in_adj    (cof_adj),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .out_cmag  (det_cmag),
        .out_info  (det_info)
    );

    mi3_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (det_valid),
        .in_ready     (det_ready),
        .in_cmag      (det_cmag),
        .in_info      (det_info),
        .out_valid    (inv_valid),
        .out_ready    (inv_ready),
        .out_res      (res),
        .out_singular (singular)
    );

    assign b00 = res[0];
    assign b01 = res[1];
    assign b02 = res[2];
    assign b10 = res[3];
    assign b11 = res[4];
    assign b12 = res[5];
    assign b20 = res[6];
    assign b21 = res[7];
    assign b22 = res[8];

    `MI3_ASSERT_IMP(a_singular_zero, clk, rst_n, inv_valid && singular, b00 == 0 && b11 == 0 && b22 == 0 && b01 == 0 && b12 == 0 && b20 == 0)
    `MI3_ASSERT_NXT(a_thr_write, clk, rst_n, wr_thr, thr_reg == $past(pwdata[mi3_pkg::THR_W-1:0]))

endmodule
